[hdl/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam logic [2:0] PH_SIZE     = 3'd0;
  localparam logic [2:0] PH_EXT      = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_SKIP     = 3'd3;
  localparam logic [2:0] PH_FINISHED = 3'd4;
  localparam logic [2:0] PH_FAILED   = 3'd5;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [1:0] TRAILER_LEN = 2'd2;

  localparam logic [1:0] ST_ZERO_CHUNK = 2'd0;
  localparam logic [1:0] ST_BETWEEN    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED  = 2'd2;
  localparam logic [1:0] ST_BAD_LINE   = 2'd3;

  typedef struct packed {
    logic [2:0] phase;
    logic       digit_seen;
    logic       line_bad;
    logic       pending_cr;
    logic [1:0] skip_left;
    logic [1:0] final_code;
  } ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       chunk_end;
    logic       done_res;
    logic [1:0] end_status;
  } res_t;

endpackage

`default_nettype wire

[hdl/hcbd_in_if.sv]
// ----------------------------------------------------------------------------
// hcbd_in_if
// Body word channel: one raw body byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_last;

  modport source (output valid, output body_byte, output body_last, input ready);
  modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

`default_nettype wire

[hdl/hcbd_out_if.sv]
// ----------------------------------------------------------------------------
// hcbd_out_if
// Result word channel: decoded byte, chunk and end flags, end status.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       chunk_end;
  logic       done_res;
  logic [1:0] end_status;

  modport source (output valid, output out_byte, output out_valid, output chunk_end,
                  output done_res, output end_status, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input chunk_end,
                  input done_res, input end_status, output ready);
endinterface

`default_nettype wire

[hdl/http_chunked_body_decoder_top.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Chunked body decoder: parses hex size lines and passes chunk payload bytes.
// ----------------------------------------------------------------------------
//  port    dir   word contents
//  body    in    body_byte[7:0], body_last
//  result  out   out_byte[7:0], out_valid, chunk_end, done_res, end_status[1:0]
//
//  One body word in, one result word out, one word per cycle while result.ready holds.
//  Each word passes through the combinational decode step into the result register.
//  A result stalled on result.ready holds the register; body.ready drops only then.
//  Synchronous reset returns the parser to the start of a size line.
//  The last word of a body returns the parser to that state as well.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  hcbd_in_if.sink     body,
  hcbd_out_if.source  result
);

  hcbd_pkg::ctl_t        ctl;
  hcbd_pkg::ctl_t        ctl_next;
  logic [SIZE_BITS-1:0]  size_accum;
  logic [SIZE_BITS-1:0]  size_accum_next;
  logic [SIZE_BITS-1:0]  bytes_left;
  logic [SIZE_BITS-1:0]  bytes_left_next;
  hcbd_pkg::res_t        res_next;
  hcbd_pkg::res_t        res;
  logic                  res_valid;
  logic                  accept;

  assign body.ready = !res_valid || result.ready;
  assign accept     = body.valid && body.ready;

  hcbd_step #(.SIZE_BITS(SIZE_BITS)) u_step (
    .ctl             (ctl),
    .size_accum      (size_accum),
    .bytes_left      (bytes_left),
    .body_byte       (body.body_byte),
    .body_last       (body.body_last),
    .ctl_next        (ctl_next),
    .size_accum_next (size_accum_next),
    .bytes_left_next (bytes_left_next),
    .res             (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= '{hcbd_pkg::PH_SIZE, 1'b0, 1'b0, 1'b0, 2'd0, 2'd0};
      size_accum <= '0;
      bytes_left <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        ctl        <= ctl_next;
        size_accum <= size_accum_next;
        bytes_left <= bytes_left_next;
        res_valid  <= 1'b1;
      end else if (result.ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.out_byte   = res.out_byte;
  assign result.out_valid  = res.out_valid;
  assign result.chunk_end  = res.chunk_end;
  assign result.done_res   = res.done_res;
  assign result.end_status = res.end_status;

  a_chunk_end_has_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.chunk_end || res.out_valid))
    else $error("chunk end without payload byte");

  a_status_only_at_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.done_res) |-> (res.end_status == hcbd_pkg::ST_ZERO_CHUNK))
    else $error("end status outside body end");

  a_data_count_live: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase == hcbd_pkg::PH_DATA) |-> (bytes_left != '0))
    else $error("payload phase with zero count");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && body.body_last) |=>
      (ctl.phase == hcbd_pkg::PH_SIZE && size_accum == '0 && !ctl.pending_cr))
    else $error("parser not restarted after body end");

endmodule

`default_nettype wire

[hdl/hcbd_step.sv]
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic for one body byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step #(
  parameter int SIZE_BITS = 32
) (
  input  hcbd_pkg::ctl_t         ctl,
  input  logic [SIZE_BITS-1:0]   size_accum,
  input  logic [SIZE_BITS-1:0]   bytes_left,
  input  logic [7:0]             body_byte,
  input  logic                   body_last,
  output hcbd_pkg::ctl_t         ctl_next,
  output logic [SIZE_BITS-1:0]   size_accum_next,
  output logic [SIZE_BITS-1:0]   bytes_left_next,
  output hcbd_pkg::res_t         res
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       line_done;
  logic [1:0] skip_dec;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
      hex_val = 4'(body_byte - 8'h30);
    end else if (body_byte >= 8'h61 && body_byte <= 8'h66) begin
      hex_val = 4'(body_byte - 8'h57);
    end else if (body_byte >= 8'h41 && body_byte <= 8'h46) begin
      hex_val = 4'(body_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    ctl_next        = ctl;
    size_accum_next = size_accum;
    bytes_left_next = bytes_left;
    res             = '0;
    line_done       = 1'b0;
    skip_dec        = ctl.skip_left - 2'd1;
    case (ctl.phase)
      hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
        if (ctl.pending_cr) begin
          ctl_next.pending_cr = 1'b0;
          if (body_byte == hcbd_pkg::CH_LF) begin
            line_done = 1'b1;
            if (ctl.line_bad || !ctl.digit_seen) begin
              ctl_next.phase      = hcbd_pkg::PH_FAILED;
              ctl_next.final_code = hcbd_pkg::ST_BAD_LINE;
            end else if (size_accum == '0) begin
              ctl_next.phase      = hcbd_pkg::PH_FINISHED;
              ctl_next.final_code = hcbd_pkg::ST_ZERO_CHUNK;
            end else begin
              ctl_next.phase  = hcbd_pkg::PH_DATA;
              bytes_left_next = size_accum;
            end
            size_accum_next     = '0;
            ctl_next.digit_seen = 1'b0;
            ctl_next.line_bad   = 1'b0;
          end else if (ctl.phase == hcbd_pkg::PH_SIZE) begin
            ctl_next.line_bad = 1'b1;
          end
        end
        if (!line_done) begin
          if (body_byte == hcbd_pkg::CH_CR) begin
            ctl_next.pending_cr = 1'b1;
          end else if (ctl.phase == hcbd_pkg::PH_SIZE) begin
            if (body_byte == hcbd_pkg::CH_SEMI) begin
              ctl_next.phase = hcbd_pkg::PH_EXT;
            end else if (!hex_ok) begin
              ctl_next.line_bad = 1'b1;
            end else begin
              ctl_next.digit_seen = 1'b1;
              if (!ctl_next.line_bad) begin
                if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                  ctl_next.line_bad = 1'b1;
                end else begin
                  size_accum_next = {size_accum[SIZE_BITS-5:0], hex_val};
                end
              end
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        res.out_byte    = body_byte;
        res.out_valid   = 1'b1;
        bytes_left_next = bytes_left - SIZE_BITS'(1);
        if (bytes_left == SIZE_BITS'(1)) begin
          res.chunk_end      = 1'b1;
          ctl_next.phase     = hcbd_pkg::PH_SKIP;
          ctl_next.skip_left = hcbd_pkg::TRAILER_LEN;
        end
      end
      hcbd_pkg::PH_SKIP: begin
        ctl_next.skip_left = skip_dec;
        if (skip_dec == 2'd0) begin
          ctl_next.phase = hcbd_pkg::PH_SIZE;
        end
      end
      default: begin
      end
    endcase

    if (body_last) begin
      res.done_res = 1'b1;
      if (ctl_next.phase == hcbd_pkg::PH_FINISHED || ctl_next.phase == hcbd_pkg::PH_FAILED) begin
        res.end_status = ctl_next.final_code;
      end else if (ctl_next.phase == hcbd_pkg::PH_DATA) begin
        res.end_status = hcbd_pkg::ST_TRUNCATED;
      end else begin
        res.end_status = hcbd_pkg::ST_BETWEEN;
      end
      ctl_next            = '0;
      ctl_next.phase      = hcbd_pkg::PH_SIZE;
      size_accum_next     = '0;
      bytes_left_next     = '0;
    end
  end

endmodule

`default_nettype wire

[tb/http_chunked_body_decoder_top_test.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_test
// Drives chunked bodies one byte per word into the decoder and checks every
// result word against a built-in model of the parser or a typed table row.
// A short table of hand-written cases comes first, then random bodies,
// mostly well-formed, with bad, oversized and cut-off size lines mixed in.
// Both channel sides idle at random, one long result stall fills the block,
// and the sender waits for the result channel to drain twice.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_top_test;

  localparam int SIZE_W       = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int WORD_TARGET  = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0]     b;
    logic           last;
    logic           typed;
    hcbd_pkg::res_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  hcbd_in_if  body();
  hcbd_out_if result();

  http_chunked_body_decoder_top #(.SIZE_BITS(SIZE_W)) uut (
    .clk    (clk),
    .rst    (rst),
    .body   (body),
    .result (result)
  );

  logic [2:0]        ph;
  logic [SIZE_W-1:0] size_acc;
  logic              got_digit;
  logic              bad_line;
  logic              cr_held;
  logic [SIZE_W-1:0] left;
  logic [1:0]        skip_cnt;
  logic [1:0]        end_code;

  hcbd_pkg::res_t decoded_q[$];
  logic [7:0]     body_bytes[$];
  dir_row_t       dir_tab[$];
  int             parsed_words = 0;
  int             errors = 0;
  int             cycles = 0;
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void parser_reset();
    ph        = hcbd_pkg::PH_SIZE;
    size_acc  = '0;
    got_digit = 1'b0;
    bad_line  = 1'b0;
    cr_held   = 1'b0;
    left      = '0;
    skip_cnt  = '0;
    end_code  = '0;
  endfunction

  function automatic hcbd_pkg::res_t decode_word(input logic [7:0] b, input logic last);
    hcbd_pkg::res_t r;
    logic [3:0]     nib;
    logic           is_hex;
    r = '0;
    nib = '0;
    is_hex = 1'b1;
    if (ph != hcbd_pkg::PH_FINISHED && ph != hcbd_pkg::PH_FAILED) parsed_words++;
    case (ph)
      hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
        if (cr_held && b == hcbd_pkg::CH_LF) begin
          cr_held = 1'b0;
          if (bad_line || !got_digit) begin
            ph = hcbd_pkg::PH_FAILED;
            end_code = hcbd_pkg::ST_BAD_LINE;
          end else if (size_acc == '0) begin
            ph = hcbd_pkg::PH_FINISHED;
            end_code = hcbd_pkg::ST_ZERO_CHUNK;
          end else begin
            ph = hcbd_pkg::PH_DATA;
            left = size_acc;
          end
          size_acc = '0;
          got_digit = 1'b0;
          bad_line = 1'b0;
        end else begin
          if (cr_held && ph == hcbd_pkg::PH_SIZE) bad_line = 1'b1;
          cr_held = 1'b0;
          if (b == hcbd_pkg::CH_CR) begin
            cr_held = 1'b1;
          end else if (ph == hcbd_pkg::PH_SIZE) begin
            if (b == hcbd_pkg::CH_SEMI) begin
              ph = hcbd_pkg::PH_EXT;
            end else begin
              if (b >= "0" && b <= "9") nib = 4'(b - "0");
              else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
              else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
              else is_hex = 1'b0;
              if (!is_hex) begin
                bad_line = 1'b1;
              end else begin
                got_digit = 1'b1;
                if (!bad_line) begin
                  if (size_acc[SIZE_W-1 -: 4] != 4'd0) bad_line = 1'b1;
                  else size_acc = {size_acc[SIZE_W-5:0], nib};
                end
              end
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        r.out_byte = b;
        r.out_valid = 1'b1;
        left = left - 1'b1;
        if (left == '0) begin
          r.chunk_end = 1'b1;
          ph = hcbd_pkg::PH_SKIP;
          skip_cnt = hcbd_pkg::TRAILER_LEN;
        end
      end
      hcbd_pkg::PH_SKIP: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == 2'd0) ph = hcbd_pkg::PH_SIZE;
      end
      default: ;
    endcase
    if (last) begin
      r.done_res = 1'b1;
      if (ph == hcbd_pkg::PH_FINISHED || ph == hcbd_pkg::PH_FAILED) begin
        r.end_status = end_code;
      end else if (ph == hcbd_pkg::PH_DATA) begin
        r.end_status = hcbd_pkg::ST_TRUNCATED;
      end else begin
        r.end_status = hcbd_pkg::ST_BETWEEN;
      end
      parser_reset();
    end
    return r;
  endfunction

  function automatic void row(input logic [7:0] b, input logic last = 1'b0,
                              input logic typed = 1'b0, input hcbd_pkg::res_t want = '0);
    dir_row_t r;
    r.b = b;
    r.last = last;
    r.typed = typed;
    r.want = want;
    dir_tab.push_back(r);
  endfunction

  function automatic hcbd_pkg::res_t end_word(input logic [1:0] st);
    hcbd_pkg::res_t r;
    r = '0;
    r.done_res = 1'b1;
    r.end_status = st;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return (($urandom_range(0, 1) == 1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic void put_size_line(input logic [31:0] size);
    int         top;
    int         pad;
    int         n;
    logic [7:0] c;
    top = 0;
    pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    for (int k = 7; k >= 0; k--) begin
      if (size[4*k +: 4] != 4'd0) begin
        top = k;
        break;
      end
    end
    repeat (pad) body_bytes.push_back("0");
    for (int k = top; k >= 0; k--) body_bytes.push_back(hex_char(size[4*k +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      body_bytes.push_back(hcbd_pkg::CH_SEMI);
      n = $urandom_range(0, 4);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        body_bytes.push_back(c);
        if (c == hcbd_pkg::CH_CR) body_bytes.push_back("x");
      end
    end
    body_bytes.push_back(hcbd_pkg::CH_CR);
    body_bytes.push_back(hcbd_pkg::CH_LF);
  endfunction

  function automatic void build_body();
    int unsigned nchunks;
    int unsigned size;
    int unsigned cut;
    body_bytes.delete();
    nchunks = $urandom_range(0, 3);
    repeat (nchunks) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      put_size_line(size);
      repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) begin
        repeat (2) body_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        body_bytes.push_back(hcbd_pkg::CH_CR);
        body_bytes.push_back(hcbd_pkg::CH_LF);
      end
    end
    case ($urandom_range(0, 9))
      6: begin
        body_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        body_bytes.push_back(8'("g" + $urandom_range(0, 19)));
        body_bytes.push_back(hcbd_pkg::CH_CR);
        body_bytes.push_back(hcbd_pkg::CH_LF);
        repeat ($urandom_range(0, 2)) body_bytes.push_back(8'($urandom_range(0, 255)));
      end
      7: begin
        if ($urandom_range(0, 1) == 0) begin
          body_bytes.push_back("1");
          body_bytes.push_back(hcbd_pkg::CH_CR);
          body_bytes.push_back("0");
        end
        body_bytes.push_back(hcbd_pkg::CH_CR);
        body_bytes.push_back(hcbd_pkg::CH_LF);
      end
      8: begin
        body_bytes.push_back("1");
        repeat ($urandom_range(8, 10)) body_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        body_bytes.push_back(hcbd_pkg::CH_CR);
        body_bytes.push_back(hcbd_pkg::CH_LF);
      end
      9: begin
        put_size_line($urandom | 32'h100);
        repeat ($urandom_range(0, 5)) body_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        put_size_line(32'd0);
        repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, body_bytes.size() - 1);
      while (body_bytes.size() > cut + 1) void'(body_bytes.pop_back());
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                           input hcbd_pkg::res_t want);
    int             gap;
    hcbd_pkg::res_t pred;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      body.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    body.valid <= 1'b1;
    body.body_byte <= b;
    body.body_last <= last;
    do @(posedge clk); while (body.ready !== 1'b1);
    pred = decode_word(b, last);
    decoded_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    body.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    int             stall;
    hcbd_pkg::res_t want;
    hcbd_pkg::res_t got;
    result.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (result.valid !== 1'b1);
      got = '{result.out_byte, result.out_valid, result.chunk_end,
              result.done_res, result.end_status};
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result word byte=%h valid=%b end=%b done=%b status=%0d",
                 $time, got.out_byte, got.out_valid, got.chunk_end, got.done_res,
                 got.end_status);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
            got.chunk_end !== want.chunk_end || got.done_res !== want.done_res ||
            got.end_status !== want.end_status) begin
          $display("%0t: expected byte=%h valid=%b end=%b done=%b status=%0d", $time,
                   want.out_byte, want.out_valid, want.chunk_end, want.done_res,
                   want.end_status);
          $display("%0t: actual   byte=%h valid=%b end=%b done=%b status=%0d", $time,
                   got.out_byte, got.out_valid, got.chunk_end, got.done_res,
                   got.end_status);
          errors++;
        end
      end
    end
  end

  initial begin
    int nbody;
    body.valid <= 1'b0;
    body.body_byte <= 8'h00;
    body.body_last <= 1'b0;
    rst <= 1'b1;
    parser_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    row("2", 1'b0, 1'b1, '0);
    row(hcbd_pkg::CH_SEMI);
    row(hcbd_pkg::CH_CR);
    row("z");
    row(hcbd_pkg::CH_CR);
    row(hcbd_pkg::CH_LF);
    row(8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 2'd0});
    row(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, hcbd_pkg::ST_BETWEEN});
    row("1");
    row(hcbd_pkg::CH_CR);
    row(hcbd_pkg::CH_LF, 1'b1, 1'b1, end_word(hcbd_pkg::ST_TRUNCATED));
    row(hcbd_pkg::CH_CR);
    row("0");
    row(hcbd_pkg::CH_CR);
    row(hcbd_pkg::CH_LF, 1'b1, 1'b1, end_word(hcbd_pkg::ST_BAD_LINE));
    row("g");
    row("x", 1'b1, 1'b1, end_word(hcbd_pkg::ST_BETWEEN));
    row("1");
    repeat (8) row("0");
    row(hcbd_pkg::CH_CR);
    row(hcbd_pkg::CH_LF, 1'b1, 1'b1, end_word(hcbd_pkg::ST_BAD_LINE));
    row("0");
    row(hcbd_pkg::CH_CR);
    row(hcbd_pkg::CH_LF, 1'b1, 1'b1, end_word(hcbd_pkg::ST_ZERO_CHUNK));

    foreach (dir_tab[k]) send_word(dir_tab[k].b, dir_tab[k].last, dir_tab[k].typed,
                                   dir_tab[k].want);
    drain_results();

    parsed_words = 0;
    nbody = 0;
    while (parsed_words < WORD_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (nbody == 4) begin
        calm = 1'b0;
        hold_req = 1'b1;
      end
      if (nbody == 30) drain_results();
      build_body();
      foreach (body_bytes[k]) send_word(body_bytes[k], k == body_bytes.size() - 1, 1'b0, '0);
      nbody++;
    end
    body.valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/hcbd_pkg.sv
hdl/hcbd_in_if.sv
hdl/hcbd_out_if.sv
hdl/hcbd_step.sv
hdl/http_chunked_body_decoder_top.sv
tb/http_chunked_body_decoder_top_test.sv
